// ----- design/lcc_pkg.sv -----
// Shared package for the linescan camera capture block.
// Holds operation codes, microcode step codes, the control word ROM and control types.
// No dependencies.
package lcc_pkg;

   localparam int PIXELS_DEF      = 128;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SAMPLE_W        = 16;
   localparam int INDEX_W         = 7;
   localparam int OP_W            = 2;

   localparam logic [OP_W-1:0] OP_START    = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
   localparam logic [OP_W-1:0] OP_SNAPSHOT = 2'd2;
   localparam logic [OP_W-1:0] OP_READ     = 2'd3;

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_CLEAR = 2'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_READ  = 2'd2;
   localparam logic [STEP_W-1:0] STEP_COPY  = 2'd3;

   localparam int COND_W = 2;
   localparam logic [COND_W-1:0] COND_ALWAYS    = 2'd0;
   localparam logic [COND_W-1:0] COND_DISPATCH  = 2'd1;
   localparam logic [COND_W-1:0] COND_COUNT_END = 2'd2;

   typedef struct packed {
      logic              clr_wr;
      logic              idle;
      logic              copy;
      logic              read_out;
      logic              cnt_zero;
      logic              cnt_inc;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jump;
   } micro_word_type;

   typedef struct packed {
      logic            take;
      logic [OP_W-1:0] op;
      logic            clr_wr;
      logic            copy;
      logic            read_out;
      logic            cnt_end;
   } seq_ctrl_type;

   // Microcode ROM: one control word per step.
   function automatic micro_word_type micro_rom(input logic [STEP_W-1:0] step);
      micro_word_type w;
      w = '0;
      case (step)
         STEP_CLEAR: begin
            w.clr_wr  = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = COND_COUNT_END;
            w.jump    = STEP_IDLE;
         end
         STEP_IDLE: begin
            w.idle     = 1'b1;
            w.cnt_zero = 1'b1;
            w.cond     = COND_DISPATCH;
            w.jump     = STEP_IDLE;
         end
         STEP_READ: begin
            w.read_out = 1'b1;
            w.cond     = COND_ALWAYS;
            w.jump     = STEP_IDLE;
         end
         STEP_COPY: begin
            w.copy    = 1'b1;
            w.cnt_inc = 1'b1;
            w.cond    = COND_COUNT_END;
            w.jump    = STEP_IDLE;
         end
         default: begin
            w.cond = COND_ALWAYS;
            w.jump = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- design/lcc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; depends on nothing.
module lcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/lcc_sequencer.sv -----
// Microcoded sequencer: step counter, control word ROM, loop counter and jumps.
// Depends on lcc_pkg.
module lcc_sequencer
   import lcc_pkg::*;
#(
   parameter int PIXELS = PIXELS_DEF,
   localparam int CW    = $clog2(PIXELS + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_operation,
   input  logic            rsp_busy,
   output logic            req_stall,
   output seq_ctrl_type    ctrl,
   output logic [CW-1:0]   count
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   micro_word_type    word;
   logic              cnt_end;
   logic              take;

   assign word      = micro_rom(step_ff);
   assign cnt_end   = (cnt_ff == CW'(PIXELS));
   assign req_stall = !word.idle || rsp_busy;
   assign take      = word.idle && req_valid && !req_stall;

   always_comb begin
      step_in = step_ff;
      case (word.cond)
         COND_ALWAYS: begin
            step_in = word.jump;
         end
         COND_DISPATCH: begin
            step_in = word.jump;
            if (take) begin
               case (req_operation)
                  OP_SNAPSHOT: step_in = STEP_COPY;
                  OP_READ:     step_in = STEP_READ;
                  default:     step_in = STEP_IDLE;
               endcase
            end
         end
         COND_COUNT_END: begin
            step_in = cnt_end ? word.jump : step_ff;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (word.cnt_zero) begin
         cnt_in = '0;
      end else if (word.cnt_inc && !cnt_end) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign ctrl.take     = take;
   assign ctrl.op       = req_operation;
   assign ctrl.clr_wr   = word.clr_wr;
   assign ctrl.copy     = word.copy;
   assign ctrl.read_out = word.read_out;
   assign ctrl.cnt_end  = cnt_end;
   assign count         = cnt_ff;

endmodule

// ----- design/lcc_datapath.sv -----
// Datapath: sensor pin state, phase counter, capture and read buffers, response register.
// Depends on lcc_pkg and lcc_ram; driven by the control struct from lcc_sequencer.
module lcc_datapath
   import lcc_pkg::*;
#(
   parameter int PIXELS      = PIXELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int CW         = $clog2(PIXELS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  seq_ctrl_type        ctrl,
   input  logic [CW-1:0]       count,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [INDEX_W-1:0]  req_pixel_index,
   input  logic                rsp_stall,
   output logic                rsp_busy,
   output logic                rsp_valid,
   output logic                rsp_clock_level,
   output logic                rsp_start_level,
   output logic                rsp_busy_res,
   output logic                rsp_line_done,
   output logic [SAMPLE_W-1:0] rsp_pixel_value
);

   localparam int AW   = $clog2(PIXELS);
   localparam int PW   = $clog2(2 * PIXELS + 1) + 1;
   localparam int CMPW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W + 1;

   localparam logic signed [PW-1:0] PH_START = PW'(-2);
   localparam logic signed [PW-1:0] PH_M1    = PW'(-1);
   localparam logic signed [PW-1:0] PH_ONE   = PW'(1);
   localparam logic signed [PW-1:0] PH_TWO   = PW'(2);
   localparam logic signed [PW-1:0] PH_END   = PW'(2 * PIXELS);

   logic signed [PW-1:0] phase_ff, phase_in;
   logic                 clk_ff, clk_in;
   logic                 start_ff, start_in;
   logic                 armed_ff, armed_in;
   logic                 store_en;
   logic [AW-1:0]        store_addr;
   logic                 tick_done;

   logic                   cap_we, cap_re;
   logic [AW-1:0]          cap_waddr;
   logic [SAMPLE_BITS-1:0] cap_wdata, cap_rdata;
   logic                   rd_we, rd_re;
   logic [AW-1:0]          rd_waddr;
   logic [SAMPLE_BITS-1:0] rd_wdata, rd_rdata;
   logic [CW-1:0]          count_m1;
   logic                   clear_wr;

   logic [CMPW-1:0] idx_wide;
   logic            in_range_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                load;
   logic                rsp_clock_ff, rsp_start_ff, rsp_armed_ff, rsp_done_ff;
   logic [SAMPLE_W-1:0] rsp_pixel_ff, pixel_in;

   always_comb begin
      clk_in     = clk_ff;
      start_in   = start_ff;
      armed_in   = armed_ff;
      phase_in   = phase_ff;
      store_en   = 1'b0;
      store_addr = '0;
      tick_done  = 1'b0;
      if (ctrl.take) begin
         case (ctrl.op)
            OP_START: begin
               armed_in = 1'b1;
            end
            OP_TICK: begin
               if (armed_ff) begin
                  clk_in = ~clk_ff;
                  if (phase_ff >= PH_TWO && phase_ff < PH_END) begin
                     if (clk_ff) begin
                        store_en   = 1'b1;
                        store_addr = phase_ff[AW:1];
                     end
                     phase_in = phase_ff + PH_ONE;
                  end else if (phase_ff < PH_TWO) begin
                     if (phase_ff == PH_M1) begin
                        start_in = 1'b1;
                     end else if (phase_ff == PH_ONE) begin
                        start_in = 1'b0;
                        store_en = 1'b1;
                     end
                     phase_in = phase_ff + PH_ONE;
                  end else begin
                     clk_in    = 1'b0;
                     phase_in  = PH_START;
                     armed_in  = 1'b0;
                     tick_done = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         clk_ff   <= 1'b0;
         start_ff <= 1'b0;
         armed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         clk_ff   <= clk_in;
         start_ff <= start_in;
         armed_ff <= armed_in;
      end
   end

   assign clear_wr  = ctrl.clr_wr && !ctrl.cnt_end;
   assign count_m1  = count - CW'(1);

   assign cap_we    = clear_wr || store_en;
   assign cap_waddr = ctrl.clr_wr ? count[AW-1:0] : store_addr;
   assign cap_wdata = ctrl.clr_wr ? '0 : req_sample[SAMPLE_BITS-1:0];
   assign cap_re    = ctrl.copy && !ctrl.cnt_end;

   assign rd_we     = clear_wr || (ctrl.copy && count != '0);
   assign rd_waddr  = ctrl.clr_wr ? count[AW-1:0] : count_m1[AW-1:0];
   assign rd_wdata  = ctrl.clr_wr ? '0 : cap_rdata;
   assign idx_wide  = CMPW'(req_pixel_index);
   assign rd_re     = ctrl.take && ctrl.op == OP_READ;

   lcc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (PIXELS)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_waddr),
      .wr_data (cap_wdata),
      .rd_en   (cap_re),
      .rd_addr (count[AW-1:0]),
      .rd_data (cap_rdata)
   );

   lcc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (PIXELS)
   ) u_read_ram (
      .clock   (clock),
      .wr_en   (rd_we),
      .wr_addr (rd_waddr),
      .wr_data (rd_wdata),
      .rd_en   (rd_re),
      .rd_addr (idx_wide[AW-1:0]),
      .rd_data (rd_rdata)
   );

   always_ff @(posedge clock) begin
      if (rd_re) begin
         in_range_ff <= idx_wide < CMPW'(PIXELS);
      end
   end

   assign load = (ctrl.take && (ctrl.op == OP_START || ctrl.op == OP_TICK))
              || ctrl.read_out || (ctrl.copy && ctrl.cnt_end);
   assign pixel_in = (ctrl.read_out && in_range_ff) ? SAMPLE_W'(rd_rdata) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_clock_ff <= clk_in;
         rsp_start_ff <= start_in;
         rsp_armed_ff <= armed_in;
         rsp_done_ff  <= tick_done;
         rsp_pixel_ff <= pixel_in;
      end
   end

   assign rsp_busy        = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_clock_level = rsp_clock_ff;
   assign rsp_start_level = rsp_start_ff;
   assign rsp_busy_res    = rsp_armed_ff;
   assign rsp_line_done   = rsp_done_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

endmodule

// ----- design/linescan_camera_capture_top.sv -----
// Top level of the linescan camera capture block.
// Depends on lcc_pkg, lcc_sequencer, lcc_datapath and lcc_ram.
//
// Each request on the req_ channel carries an operation: start arms a line capture, tick is
// one half-period of the sensor clock with the latest converter sample, snapshot copies the
// capture buffer into the read buffer and read returns one pixel of the read buffer.
// Every request gives exactly one response on the rsp_ channel with the sensor clock and SI
// levels, the armed flag, the end-of-line flag and the pixel value.
// Start and tick: the response is valid on the cycle after acceptance.
// A read passes through the registered read port of the read buffer, then the response register.
// A snapshot copies one buffer entry per cycle through the single read port of the capture
// buffer, and then writes the last entry into the read buffer.
// The microcode sequencer works on one request at a time; req_stall is high while it runs.
// After reset both buffers are cleared, one entry per cycle, while req_stall is high;
// the pins read low and the phase counter restarts.
// While the receiver stalls, the response is held and no new request is taken.
module linescan_camera_capture_top
   import lcc_pkg::*;
#(
   parameter int PIXELS      = PIXELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [INDEX_W-1:0]  req_pixel_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_clock_level,
   output logic                rsp_start_level,
   output logic                rsp_busy_res,
   output logic                rsp_line_done,
   output logic [SAMPLE_W-1:0] rsp_pixel_value
);

   localparam int CW = $clog2(PIXELS + 1);

   seq_ctrl_type  ctrl;
   logic [CW-1:0] count;
   logic          rsp_busy;

   lcc_sequencer #(
      .PIXELS (PIXELS)
   ) u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .rsp_busy      (rsp_busy),
      .req_stall     (req_stall),
      .ctrl          (ctrl),
      .count         (count)
   );

   lcc_datapath #(
      .PIXELS      (PIXELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .count           (count),
      .req_sample      (req_sample),
      .req_pixel_index (req_pixel_index),
      .rsp_stall       (rsp_stall),
      .rsp_busy        (rsp_busy),
      .rsp_valid       (rsp_valid),
      .rsp_clock_level (rsp_clock_level),
      .rsp_start_level (rsp_start_level),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_line_done   (rsp_line_done),
      .rsp_pixel_value (rsp_pixel_value)
   );

endmodule
